// File: rtl/core/sobth_pkg.sv
// sobth_pkg: shared widths, constants and payload types for the sobel edge threshold core
// no dependencies; imported by every module under rtl/core

package sobth_pkg;

   // geometry
   localparam int LINE_DEPTH = 2048;
   localparam int COL_W      = $clog2(LINE_DEPTH);
   localparam int ROW_W      = 12;
   localparam int PIX_W      = 8;
   localparam int WIN_TAPS   = 9;

   // configuration register widths and reset values
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 12;
   localparam int THRESH_W     = 8;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WIDTH_REG_W-1:0]  RESET_FRAME_WIDTH    = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] RESET_FRAME_HEIGHT   = 12'd480;
   localparam logic [THRESH_W-1:0]     RESET_EDGE_THRESHOLD = 8'd127;
   localparam logic [WIDTH_REG_W-1:0]  MIN_FRAME_DIM        = 12'd3;
   localparam logic [WIDTH_REG_W-1:0]  MAX_FRAME_WIDTH      = WIDTH_REG_W'(LINE_DEPTH);
   localparam logic [COL_W-1:0]        RESET_LAST_COL       = COL_W'(RESET_FRAME_WIDTH - 12'd1);
   localparam logic [ROW_W-1:0]        RESET_LAST_ROW       = RESET_FRAME_HEIGHT - 12'd1;
   localparam logic [THRESH_W-1:0]     THRESH_NEVER         = 8'd255;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

   // gray = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
   localparam int GRAY_SUM_W  = 10;
   localparam int GRAY_PROD_W = 20;
   localparam logic [GRAY_PROD_W-1:0] GRAY_MUL = 20'd683;
   localparam int GRAY_SHIFT  = 11;

   // result pixel codes
   localparam logic [PIX_W-1:0] PIX_EDGE = 8'd0;
   localparam logic [PIX_W-1:0] PIX_FLAT = 8'd255;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // gradient datapath widths
   localparam int GRAD_W = 10;
   localparam int SQ_W   = 2 * GRAD_W;
   localparam int MAG_W  = SQ_W + 1;
   localparam int TSQ_W  = 17;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [COL_W-1:0]    last_col;
      logic [ROW_W-1:0]    last_row;
      logic [THRESH_W-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic [WIN_TAPS-1:0][PIX_W-1:0] win;
      logic [COL_W-1:0]               col;
      logic [ROW_W-1:0]               row;
      logic                           frame_end;
   } win_item_type;

endpackage

// File: rtl/core/sobel_edge_threshold_core.sv
// sobel_edge_threshold_core: top level of the streaming 3x3 sobel edge threshold block
// depends on sobth_pkg, sobth_csr, sobth_front, sobth_fifo, sobth_back
//
//   port group   direction   handshake                    payload
//   req_*        in          req_valid / req_ready        req_type: red, green, blue, frame_start
//   rsp_*        out         rsp_valid / rsp_ready        rsp_type: pixel_value, out_col, out_row,
//                                                         frame_end
//   csr_*        in/out      psel, penable, pwrite        frame_width, frame_height,
//                                                         edge_threshold at 0x0, 0x4, 0x8
//
// one pixel per clock sustained unless the window queue fills or rsp_ready holds the output;
// the line store read and write-back stage sets that pace; a result passes the store stage,
// the window queue and gradient stages a, b and c; a 4-entry window queue between front and
// back lets either side stall alone; the front takes requests while at least two slots are free
// reset is synchronous; line stores hold no reset state and need no clearing pass

module sobel_edge_threshold_core
   import sobth_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                 cfg;
   logic                    push, pop, head_valid;
   win_item_type            push_item, head;
   logic [FIFO_CNT_W-1:0]   fifo_cnt;

   sobth_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sobth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .fifo_cnt  (fifo_cnt),
      .push      (push),
      .push_item (push_item)
   );

   sobth_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid),
      .count     (fifo_cnt)
   );

   sobth_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/core/sobth_csr.sv
// sobth_csr: apb-style configuration registers and derived last column / last row limits
// depends on sobth_pkg

module sobth_csr
   import sobth_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [THRESH_W-1:0]     thresh_ff, thresh_in;
   logic [COL_W-1:0]        last_col_ff, last_col_in;
   logic [ROW_W-1:0]        last_row_ff, last_row_in;

   logic                    wr_en;
   logic [1:0]              reg_idx;
   logic [WIDTH_REG_W-1:0]  wdat_w, eff_w;
   logic [HEIGHT_REG_W-1:0] wdat_h, eff_h;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[3:2];
   assign wdat_w  = csr_pwdata[WIDTH_REG_W-1:0];
   assign wdat_h  = csr_pwdata[HEIGHT_REG_W-1:0];

   // clamp on write so the pixel path only compares
   always_comb begin
      if (wdat_w < MIN_FRAME_DIM) begin
         eff_w = MIN_FRAME_DIM;
      end else if (wdat_w > MAX_FRAME_WIDTH) begin
         eff_w = MAX_FRAME_WIDTH;
      end else begin
         eff_w = wdat_w;
      end
      if (wdat_h < MIN_FRAME_DIM) begin
         eff_h = MIN_FRAME_DIM;
      end else begin
         eff_h = wdat_h;
      end
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      thresh_in   = thresh_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH: begin
               width_in    = wdat_w;
               last_col_in = COL_W'(eff_w - 12'd1);
            end
            REG_FRAME_HEIGHT: begin
               height_in   = wdat_h;
               last_row_in = eff_h - 12'd1;
            end
            REG_EDGE_THRESHOLD: begin
               thresh_in = csr_pwdata[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_FRAME_WIDTH;
         height_ff   <= RESET_FRAME_HEIGHT;
         thresh_ff   <= RESET_EDGE_THRESHOLD;
         last_col_ff <= RESET_LAST_COL;
         last_row_ff <= RESET_LAST_ROW;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         thresh_ff   <= thresh_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_WIDTH:    csr_prdata = CSR_DATA_W'(width_ff);
         REG_FRAME_HEIGHT:   csr_prdata = CSR_DATA_W'(height_ff);
         REG_EDGE_THRESHOLD: csr_prdata = CSR_DATA_W'(thresh_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign cfg.last_col  = last_col_ff;
   assign cfg.last_row  = last_row_ff;
   assign cfg.threshold = thresh_ff;

endmodule

// File: rtl/core/sobth_front.sv
// sobth_front: request intake, gray conversion, raster counters, two line stores and 3x3 window
// depends on sobth_pkg; pushes complete interior windows into sobth_fifo

module sobth_front
   import sobth_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  cfg_type               cfg,
   input  logic [FIFO_CNT_W-1:0] fifo_cnt,
   output logic                  push,
   output win_item_type          push_item
);

   logic                   accept;
   logic [COL_W-1:0]       cur_col, col_ff, col_in;
   logic [ROW_W-1:0]       cur_row, row_ff, row_in;
   logic                   last_col, last_row;
   logic [GRAY_SUM_W-1:0]  gray_sum;
   logic [GRAY_PROD_W-1:0] gray_prod;
   logic [PIX_W-1:0]       gray;

   logic [PIX_W-1:0] upper_mem [LINE_DEPTH];
   logic [PIX_W-1:0] middle_mem [LINE_DEPTH];
   logic [PIX_W-1:0] upper_rd_ff, middle_rd_ff;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_gray_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_emit_ff, s1_end_ff;
   logic             s1_fwd_ff, s1_fwd_in;
   logic [PIX_W-1:0] s1_fwd_up_ff, s1_fwd_mid_ff;
   logic [PIX_W-1:0] s1_up, s1_mid;

   logic [WIN_TAPS-1:0][PIX_W-1:0] win_ff, win_in;

   // two free slots cover the item still in the store stage
   assign req_ready = (fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign accept    = req_valid & req_ready;

   assign cur_col  = req_data.frame_start ? '0 : col_ff;
   assign cur_row  = req_data.frame_start ? '0 : row_ff;
   assign last_col = (cur_col >= cfg.last_col);
   assign last_row = (cur_row >= cfg.last_row);

   assign gray_sum  = GRAY_SUM_W'(req_data.red) + GRAY_SUM_W'(req_data.green)
                    + GRAY_SUM_W'(req_data.blue);
   assign gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_MUL;
   assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : cur_row + 12'd1;
         end else begin
            col_in = cur_col + 11'd1;
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
      end
   end

   // store stage writes the address that the next request may be reading right now
   assign s1_valid_in = accept;
   assign s1_fwd_in   = s1_valid_ff && (s1_col_ff == cur_col);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff    <= gray;
         s1_col_ff     <= cur_col;
         s1_row_ff     <= cur_row;
         s1_emit_ff    <= (cur_col >= 11'd2) && (cur_row >= 12'd2);
         s1_end_ff     <= last_col && last_row;
         s1_fwd_ff     <= s1_fwd_in;
         s1_fwd_up_ff  <= s1_mid;
         s1_fwd_mid_ff <= s1_gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff <= upper_mem[cur_col];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_col_ff] <= s1_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         middle_rd_ff <= middle_mem[cur_col];
      end
      if (s1_valid_ff) begin
         middle_mem[s1_col_ff] <= s1_gray_ff;
      end
   end

   assign s1_up  = s1_fwd_ff ? s1_fwd_up_ff  : upper_rd_ff;
   assign s1_mid = s1_fwd_ff ? s1_fwd_mid_ff : middle_rd_ff;

   // taps 0..2 oldest row, rightmost tap takes the new column
   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = s1_up;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = s1_mid;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s1_gray_ff;
      end
   end

   assign push                = s1_valid_ff && s1_emit_ff;
   assign push_item.win       = win_in;
   assign push_item.col       = s1_col_ff - 11'd1;
   assign push_item.row       = s1_row_ff - 12'd1;
   assign push_item.frame_end = s1_end_ff;

`ifndef SYNTH
   a_push_interior: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_item.col >= 11'd1) && (push_item.row >= 12'd1))
      else $error("window pushed for a border pixel");

   a_fwd_same_col: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_fwd_ff |-> $past(s1_valid_ff) && ($past(s1_col_ff) == s1_col_ff))
      else $error("line store bypass taken for a different column");
`endif

endmodule

// File: rtl/core/sobth_fifo.sv
// sobth_fifo: short window queue between the line store front and the gradient back end
// depends on sobth_pkg

module sobth_fifo
   import sobth_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  win_item_type          push_item,
   input  logic                  pop,
   output win_item_type          head,
   output logic                  not_empty,
   output logic [FIFO_CNT_W-1:0] count
);

   win_item_type            entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH)) |-> pop)
      else $error("window queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("window queue popped while empty");
`endif

endmodule

// File: rtl/core/sobth_back.sv
// sobth_back: sobel gradients, squared magnitude compare and the result output register
// depends on sobth_pkg; drains sobth_fifo

module sobth_back
   import sobth_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  win_item_type head,
   input  logic         head_valid,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   // stage a: absolute gradients
   logic              a_valid_ff, a_valid_in, a_take;
   logic [GRAD_W-1:0] a_ax_ff, a_ay_ff, a_ax_in, a_ay_in;
   logic [COL_W-1:0]  a_col_ff;
   logic [ROW_W-1:0]  a_row_ff;
   logic              a_end_ff;

   // stage b: squares
   logic              b_valid_ff, b_valid_in, b_take;
   logic [SQ_W-1:0]   b_sqx_ff, b_sqy_ff;
   logic [TSQ_W-1:0]  b_tsq_ff, b_tsq_in;
   logic              b_never_ff;
   logic [COL_W-1:0]  b_col_ff;
   logic [ROW_W-1:0]  b_row_ff;
   logic              b_end_ff;
   logic [THRESH_W:0] t_plus;

   // stage c: output register
   logic              c_valid_ff, c_valid_in, c_take;
   rsp_type           c_rsp_ff, c_rsp_in;
   logic [MAG_W-1:0]  mag_sq;
   logic              is_edge;

   logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

   assign c_take = !c_valid_ff || rsp_ready;
   assign b_take = !b_valid_ff || c_take;
   assign a_take = !a_valid_ff || b_take;
   assign pop    = head_valid && a_take;

   always_comb begin
      a_valid_in = a_take ? head_valid : a_valid_ff;
      b_valid_in = b_take ? a_valid_ff : b_valid_ff;
      c_valid_in = c_take ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // each side of a kernel is at most 4*255, so the halves stay unsigned
   assign gx_pos = GRAD_W'(head.win[2]) + {head.win[5], 1'b0} + GRAD_W'(head.win[8]);
   assign gx_neg = GRAD_W'(head.win[0]) + {head.win[3], 1'b0} + GRAD_W'(head.win[6]);
   assign gy_pos = GRAD_W'(head.win[6]) + {head.win[7], 1'b0} + GRAD_W'(head.win[8]);
   assign gy_neg = GRAD_W'(head.win[0]) + {head.win[1], 1'b0} + GRAD_W'(head.win[2]);
   assign a_ax_in = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
   assign a_ay_in = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;

   always_ff @(posedge clock) begin
      if (pop) begin
         a_ax_ff  <= a_ax_in;
         a_ay_ff  <= a_ay_in;
         a_col_ff <= head.col;
         a_row_ff <= head.row;
         a_end_ff <= head.frame_end;
      end
   end

   assign t_plus   = (THRESH_W + 1)'(cfg.threshold) + 9'd1;
   assign b_tsq_in = TSQ_W'(TSQ_W'(t_plus) * TSQ_W'(t_plus));

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_take) begin
         b_sqx_ff   <= SQ_W'(a_ax_ff) * SQ_W'(a_ax_ff);
         b_sqy_ff   <= SQ_W'(a_ay_ff) * SQ_W'(a_ay_ff);
         b_tsq_ff   <= b_tsq_in;
         b_never_ff <= (cfg.threshold == THRESH_NEVER);
         b_col_ff   <= a_col_ff;
         b_row_ff   <= a_row_ff;
         b_end_ff   <= a_end_ff;
      end
   end

   assign mag_sq  = MAG_W'(b_sqx_ff) + MAG_W'(b_sqy_ff);
   assign is_edge = !b_never_ff && (mag_sq >= MAG_W'(b_tsq_ff));

   always_comb begin
      c_rsp_in.pixel_value = is_edge ? PIX_EDGE : PIX_FLAT;
      c_rsp_in.out_col     = b_col_ff;
      c_rsp_in.out_row     = b_row_ff;
      c_rsp_in.frame_end   = b_end_ff;
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff && c_take) begin
         c_rsp_ff <= c_rsp_in;
      end
   end

   assign rsp_valid = c_valid_ff;
   assign rsp_data  = c_rsp_ff;

`ifndef SYNTH
   a_stage_a_holds: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_take |=> a_valid_ff)
      else $error("gradient stage dropped an item under stall");

   a_stage_b_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !c_take |=> b_valid_ff && $stable(b_sqx_ff) && $stable(b_sqy_ff))
      else $error("square stage changed under stall");
`endif

endmodule
